// ===== rtl/rpc_rwp_pkg.sv =====
// rpc reply word parser package: parse phases, reply kinds, protocol codes
// and the result record shared by the parser, the result queue and the top level
// no dependencies
`default_nettype none

package rpc_rwp_pkg;

  localparam logic [31:0] REPLY_MSG_TYPE     = 32'd1;
  localparam logic [31:0] RPC_MSG_ACCEPTED   = 32'd0;
  localparam logic [31:0] RPC_ACCEPT_SUCCESS = 32'd0;

  localparam int VWORDS_W = 31;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [3:0] {
    PH_XID     = 4'd0,
    PH_MTYPE   = 4'd1,
    PH_RSTAT   = 4'd2,
    PH_VFLAVOR = 4'd3,
    PH_VLEN    = 4'd4,
    PH_VBODY   = 4'd5,
    PH_ASTAT   = 4'd6,
    PH_RES0    = 4'd7,
    PH_RES1    = 4'd8,
    PH_RES2    = 4'd9,
    PH_RES3    = 4'd10,
    PH_DATA    = 4'd11,
    PH_DONE    = 4'd12
  } phase_t;

  typedef enum logic [2:0] {
    KIND_SINGLE  = 3'd0,
    KIND_CREATE  = 3'd1,
    KIND_WRITE   = 3'd2,
    KIND_READ    = 3'd3,
    KIND_READSTB = 3'd4
  } kind_t;

  typedef struct packed {
    logic               is_status;
    logic               last_result;
    logic [31:0]        data_word;
    logic [2:0]         data_bytes;
    logic               parse_ok;
    logic [31:0]        transaction_id;
    logic signed [31:0] error_code;
    logic signed [31:0] value_a;
    logic [31:0]        value_b;
    logic [31:0]        value_c;
    logic [31:0]        payload_length;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/rpc_rwp_parser.sv =====
// rpc reply word parser core: per-message state and result decode, one word per cycle while go is high
// depends on rpc_rwp_pkg
`default_nettype none

module rpc_rwp_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                go,
  input  wire logic [31:0]         word,
  input  wire logic                last_word,
  input  wire logic [2:0]          reply_kind,
  output logic [1:0]               push_cnt,
  output rpc_rwp_pkg::result_t     res0,
  output rpc_rwp_pkg::result_t     res1
);
  import rpc_rwp_pkg::*;

  phase_t                phase_r, phase_nxt;
  logic [VWORDS_W-1:0]   vleft_r, vleft_nxt;
  logic [31:0]           oleft_r, oleft_nxt;
  kind_t                 kind_r, kind_nxt;
  logic                  good_r, good_nxt;
  logic [31:0]           xid_r, xid_nxt;
  logic [31:0]           err_r, err_nxt;
  logic [31:0]           va_r, va_nxt;
  logic [31:0]           vb_r, vb_nxt;
  logic [31:0]           vc_r, vc_nxt;
  logic [31:0]           len_r, len_nxt;

  logic [VWORDS_W-1:0]   vcount;
  logic [2:0]            nb;
  logic                  emit_data;
  result_t               data_res;
  result_t               stat_res;

  assign vcount = {1'b0, word[31:2]} + VWORDS_W'(|word[1:0]);
  assign nb     = (oleft_r >= 32'd4) ? 3'd4 : oleft_r[2:0];

  always_comb begin
    phase_nxt = phase_r;
    vleft_nxt = vleft_r;
    oleft_nxt = oleft_r;
    kind_nxt  = kind_r;
    good_nxt  = good_r;
    xid_nxt   = xid_r;
    err_nxt   = err_r;
    va_nxt    = va_r;
    vb_nxt    = vb_r;
    vc_nxt    = vc_r;
    len_nxt   = len_r;
    emit_data = 1'b0;
    unique case (phase_r)
      PH_XID: begin
        xid_nxt   = word;
        kind_nxt  = (reply_kind <= 3'(KIND_READSTB)) ? kind_t'(reply_kind) : KIND_SINGLE;
        phase_nxt = PH_MTYPE;
      end
      PH_MTYPE: begin
        if (word != REPLY_MSG_TYPE) begin
          good_nxt  = 1'b0;
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_RSTAT;
        end
      end
      PH_RSTAT: begin
        if (word != RPC_MSG_ACCEPTED) begin
          good_nxt  = 1'b0;
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_VFLAVOR;
        end
      end
      PH_VFLAVOR: phase_nxt = PH_VLEN;
      PH_VLEN: begin
        vleft_nxt = vcount;
        phase_nxt = (vcount == '0) ? PH_ASTAT : PH_VBODY;
      end
      PH_VBODY: begin
        vleft_nxt = vleft_r - VWORDS_W'(1);
        if (vleft_r == VWORDS_W'(1)) phase_nxt = PH_ASTAT;
      end
      PH_ASTAT: begin
        if (word != RPC_ACCEPT_SUCCESS) begin
          good_nxt  = 1'b0;
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_RES0;
        end
      end
      PH_RES0: begin
        err_nxt   = word;
        phase_nxt = (kind_r == KIND_SINGLE) ? PH_DONE : PH_RES1;
      end
      PH_RES1: begin
        va_nxt    = (kind_r == KIND_READSTB) ? {24'd0, word[7:0]} : word;
        phase_nxt = (kind_r == KIND_CREATE || kind_r == KIND_READ) ? PH_RES2 : PH_DONE;
      end
      PH_RES2: begin
        if (kind_r == KIND_READ) begin
          len_nxt   = word;
          oleft_nxt = word;
          phase_nxt = (word == 32'd0) ? PH_DONE : PH_DATA;
        end else begin
          vb_nxt    = word;
          phase_nxt = PH_RES3;
        end
      end
      PH_RES3: begin
        vc_nxt    = word;
        phase_nxt = PH_DONE;
      end
      PH_DATA: begin
        emit_data = 1'b1;
        oleft_nxt = oleft_r - {29'd0, nb};
        if (oleft_r == {29'd0, nb}) phase_nxt = PH_DONE;
      end
      default: ;
    endcase
  end

  always_comb begin
    data_res             = '0;
    data_res.data_word   = word;
    data_res.data_bytes  = nb;
    data_res.last_result = !last_word;

    stat_res                = '0;
    stat_res.is_status      = 1'b1;
    stat_res.last_result    = 1'b1;
    stat_res.parse_ok       = good_nxt && (phase_nxt == PH_DONE);
    stat_res.transaction_id = xid_nxt;
    stat_res.error_code     = err_nxt;
    stat_res.value_a        = va_nxt;
    stat_res.value_b        = vb_nxt;
    stat_res.value_c        = vc_nxt;
    stat_res.payload_length = len_nxt;

    push_cnt = go ? (2'(emit_data) + 2'(last_word)) : 2'd0;
    res0     = emit_data ? data_res : stat_res;
    res1     = stat_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (go && last_word)) begin
      phase_r <= PH_XID;
      vleft_r <= '0;
      oleft_r <= '0;
      kind_r  <= KIND_SINGLE;
      good_r  <= 1'b1;
      xid_r   <= '0;
      err_r   <= '0;
      va_r    <= '0;
      vb_r    <= '0;
      vc_r    <= '0;
      len_r   <= '0;
    end else if (go) begin
      phase_r <= phase_nxt;
      vleft_r <= vleft_nxt;
      oleft_r <= oleft_nxt;
      kind_r  <= kind_nxt;
      good_r  <= good_nxt;
      xid_r   <= xid_nxt;
      err_r   <= err_nxt;
      va_r    <= va_nxt;
      vb_r    <= vb_nxt;
      vc_r    <= vc_nxt;
      len_r   <= len_nxt;
    end
  end

`ifndef SYNTHESIS
  a_vleft_only_in_body: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_VBODY) |-> (vleft_r == '0))
    else $error("verifier count nonzero outside verifier body");
  a_data_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DATA) |-> (oleft_r != 32'd0))
    else $error("data phase with no opaque bytes left");
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (go && last_word) |=> (phase_r == PH_XID && good_r))
    else $error("message state not cleared after last word");
`endif

endmodule

`default_nettype wire

// ===== rtl/rpc_rwp_out_fifo.sv =====
// rpc reply word parser result queue: takes up to two results per cycle, gives one
// depends on rpc_rwp_pkg
`default_nettype none

module rpc_rwp_out_fifo (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic [1:0]          push_cnt,
  input  rpc_rwp_pkg::result_t     d0,
  input  rpc_rwp_pkg::result_t     d1,
  input  wire logic                pop,
  output logic                     room2,
  output logic                     head_valid,
  output rpc_rwp_pkg::result_t     head
);
  import rpc_rwp_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  result_t         mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     cnt_r, cnt_nxt;
  logic            do_pop;

  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign room2      = (cnt_r <= (PW+1)'(QUEUE_DEPTH - 2));
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + PW'(do_pop);
    cnt_nxt    = cnt_r + (PW+1)'(push_cnt) - (PW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) mem_r[wr_ptr_r] <= d0;
    if (push_cnt == 2'd2) mem_r[wr_ptr_r + PW'(1)] <= d1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push_cnt != 2'd0) |-> room2)
    else $error("result pushed into full queue");
`endif

endmodule

`default_nettype wire

// ===== rtl/rpc_reply_word_parser_top.sv =====
// a word accepted into the input register is parsed from there and its results are written
// to the result queue, whose head drives out_*
// throughput: one word per cycle while the queue has room for two results, set by the
// single parser pass per word; a data word that is also the last word gives two results
// reset: rst_n synchronous active low, clears input stage, message state and queue
// top level: input register, parser core and result queue; depends on rpc_rwp_pkg
`default_nettype none

module rpc_reply_word_parser_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [31:0]   in_tdata,   // word[31:0]
  input  wire logic          in_tlast,
  input  wire logic [2:0]    in_tuser,   // reply_kind[2:0]
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // data_word[31:0] data_bytes[34:32] parse_ok[35] transaction_id[67:36]
  // error_code[99:68] value_a[131:100] value_b[163:132] value_c[195:164]
  // payload_length[227:196] zero[231:228]
  output logic [231:0]       out_tdata,
  output logic               out_tlast,
  output logic               out_tuser   // is_status
);
  import rpc_rwp_pkg::*;

  logic          s1_valid_r;
  logic [31:0]   s1_word_r;
  logic          s1_last_r;
  logic [2:0]    s1_kind_r;
  logic          s1_go;
  logic          room2;
  logic [1:0]    push_cnt;
  result_t       res0, res1, head;

  assign s1_go     = s1_valid_r && room2;
  assign in_tready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_word_r <= in_tdata;
      s1_last_r <= in_tlast;
      s1_kind_r <= in_tuser;
    end
  end

  rpc_rwp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (s1_go),
    .word       (s1_word_r),
    .last_word  (s1_last_r),
    .reply_kind (s1_kind_r),
    .push_cnt   (push_cnt),
    .res0       (res0),
    .res1       (res1)
  );

  rpc_rwp_out_fifo u_out_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .d0         (res0),
    .d1         (res1),
    .pop        (out_tready),
    .room2      (room2),
    .head_valid (out_tvalid),
    .head       (head)
  );

  assign out_tuser = head.is_status;
  assign out_tlast = head.last_result;
  assign out_tdata = {4'd0, head.payload_length, head.value_c, head.value_b,
                      head.value_a, head.error_code, head.transaction_id,
                      head.parse_ok, head.data_bytes, head.data_word};

`ifndef SYNTHESIS
  a_stalled_word_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_word_r) && $stable(s1_last_r)))
    else $error("held input word lost while queue full");
`endif

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for rpc_reply_word_parser_top: streams whole, broken and
// noise rpc reply messages and checks every result against an in-bench parser model
// depends on rpc_rwp_pkg and rpc_reply_word_parser_top
`timescale 1ns / 1ps

module tb;
  import rpc_rwp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_WORDS = 160;

  typedef struct {
    logic [31:0] w;
    bit          last;
    logic [2:0]  kind;
  } word_item_t;

  class rpc_reply_scoreboard;
    phase_t      phase;
    logic [30:0] vwords_left;
    logic [31:0] bytes_left;
    kind_t       kind;
    bit          hdr_ok;
    logic [31:0] xid, err_word, val_a, val_b, val_c, rd_len;
    result_t     results_due[$];
    int unsigned mismatches;

    function new();
      clear_msg();
      mismatches = 0;
    endfunction

    function void clear_msg();
      phase = PH_XID;
      vwords_left = '0;
      bytes_left = '0;
      kind = KIND_SINGLE;
      hdr_ok = 1'b1;
      xid = '0;
      err_word = '0;
      val_a = '0;
      val_b = '0;
      val_c = '0;
      rd_len = '0;
    endfunction

    function void fail_hdr();
      hdr_ok = 1'b0;
      phase = PH_DONE;
    endfunction

    function void note_word(logic [31:0] w, bit last, logic [2:0] k);
      result_t r;
      logic [31:0] nb;
      case (phase)
        PH_XID: begin
          xid = w;
          kind = (k <= KIND_READSTB) ? kind_t'(k) : KIND_SINGLE;
          phase = PH_MTYPE;
        end
        PH_MTYPE: begin
          if (w != REPLY_MSG_TYPE) fail_hdr();
          else phase = PH_RSTAT;
        end
        PH_RSTAT: begin
          if (w != RPC_MSG_ACCEPTED) fail_hdr();
          else phase = PH_VFLAVOR;
        end
        PH_VFLAVOR: phase = PH_VLEN;
        PH_VLEN: begin
          vwords_left = {1'b0, w[31:2]} + 31'(w[1:0] != 2'b00);
          phase = (vwords_left == '0) ? PH_ASTAT : PH_VBODY;
        end
        PH_VBODY: begin
          vwords_left = vwords_left - 31'd1;
          if (vwords_left == '0) phase = PH_ASTAT;
        end
        PH_ASTAT: begin
          if (w != RPC_ACCEPT_SUCCESS) fail_hdr();
          else phase = PH_RES0;
        end
        PH_RES0: begin
          err_word = w;
          phase = (kind == KIND_SINGLE) ? PH_DONE : PH_RES1;
        end
        PH_RES1: begin
          val_a = (kind == KIND_READSTB) ? {24'd0, w[7:0]} : w;
          phase = (kind == KIND_CREATE || kind == KIND_READ) ? PH_RES2 : PH_DONE;
        end
        PH_RES2: begin
          if (kind == KIND_READ) begin
            rd_len = w;
            bytes_left = w;
            phase = (w == '0) ? PH_DONE : PH_DATA;
          end else begin
            val_b = w;
            phase = PH_RES3;
          end
        end
        PH_RES3: begin
          val_c = w;
          phase = PH_DONE;
        end
        PH_DATA: begin
          nb = (bytes_left >= 32'd4) ? 32'd4 : bytes_left;
          r = '0;
          r.data_word = w;
          r.data_bytes = nb[2:0];
          r.last_result = !last;
          results_due.push_back(r);
          bytes_left = bytes_left - nb;
          if (bytes_left == '0) phase = PH_DONE;
        end
        default: ;
      endcase
      if (last) begin
        r = '0;
        r.is_status = 1'b1;
        r.last_result = 1'b1;
        r.parse_ok = hdr_ok && (phase == PH_DONE);
        r.transaction_id = xid;
        r.error_code = err_word;
        r.value_a = val_a;
        r.value_b = val_b;
        r.value_c = val_c;
        r.payload_length = rd_len;
        results_due.push_back(r);
        clear_msg();
      end
    endfunction

    function void cmp(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %h, actual %h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic [231:0] d, logic lst, logic usr);
      result_t e;
      if (results_due.size() == 0) begin
        $error("unexpected result transaction: tdata %h tlast %b tuser %b", d, lst, usr);
        mismatches++;
        return;
      end
      e = results_due.pop_front();
      cmp("is_status", e.is_status, usr);
      cmp("last_result", e.last_result, lst);
      cmp("data_word", e.data_word, d[31:0]);
      cmp("data_bytes", e.data_bytes, d[34:32]);
      cmp("parse_ok", e.parse_ok, d[35]);
      cmp("transaction_id", e.transaction_id, d[67:36]);
      cmp("error_code", e.error_code, d[99:68]);
      cmp("value_a", e.value_a, d[131:100]);
      cmp("value_b", e.value_b, d[163:132]);
      cmp("value_c", e.value_c, d[195:164]);
      cmp("payload_length", e.payload_length, d[227:196]);
      cmp("pad", 32'd0, d[231:228]);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [31:0] in_tdata;
  logic [2:0] in_tuser;
  logic out_tvalid, out_tready, out_tlast, out_tuser;
  logic [231:0] out_tdata;

  rpc_reply_scoreboard sb = new();
  word_item_t word_q[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int unsigned cycle_count = 0;

  rpc_reply_word_parser_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) out_tready = ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] bad_code(logic [31:0] good);
    logic [31:0] flip;
    flip = rand_word();
    if (flip == '0) flip = 32'h1 << $urandom_range(31);
    return good ^ flip;
  endfunction

  function automatic void queue_words(logic [31:0] w[$], logic [2:0] kind);
    word_item_t it;
    foreach (w[i]) begin
      it.w = w[i];
      it.last = (i == w.size() - 1);
      it.kind = (i == 0) ? kind : 3'($urandom_range(7));
      word_q.push_back(it);
    end
  endfunction

  // brk: 1 bad message type, 2 bad reply status, 3 bad accept status
  // keep: truncate to this many words when nonzero; extra: trailing words
  function automatic void build_msg(int kind, logic [31:0] vlen, logic [31:0] dlen,
                                    int brk, int keep, int extra);
    logic [31:0] w[$];
    int nbody, ndata, rk;
    w.push_back(rand_word());
    w.push_back(REPLY_MSG_TYPE);
    w.push_back(RPC_MSG_ACCEPTED);
    w.push_back(rand_word());
    w.push_back(vlen);
    nbody = (vlen > 32'd32) ? 8 : int'((vlen + 32'd3) / 32'd4);
    repeat (nbody) w.push_back(rand_word());
    w.push_back(RPC_ACCEPT_SUCCESS);
    rk = (kind > KIND_READSTB) ? int'(KIND_SINGLE) : kind;
    w.push_back(rand_word());
    if (rk != KIND_SINGLE) w.push_back(rand_word());
    if (rk == KIND_CREATE) begin
      w.push_back(rand_word());
      w.push_back(rand_word());
    end
    if (rk == KIND_READ) begin
      w.push_back(dlen);
      ndata = (dlen > 32'd32) ? 8 : int'((dlen + 32'd3) / 32'd4);
      repeat (ndata) w.push_back(rand_word());
    end
    case (brk)
      1: w[1] = bad_code(REPLY_MSG_TYPE);
      2: w[2] = bad_code(RPC_MSG_ACCEPTED);
      3: w[5 + nbody] = bad_code(RPC_ACCEPT_SUCCESS);
      default: ;
    endcase
    if (keep > 0) while (w.size() > keep) void'(w.pop_back());
    repeat (extra) w.push_back(rand_word());
    queue_words(w, 3'(kind));
  endfunction

  function automatic void build_noise(int n);
    logic [31:0] w[$];
    repeat (n) w.push_back(rand_word());
    queue_words(w, 3'($urandom_range(7)));
  endfunction

  function automatic void random_msg();
    int r, kind;
    logic [31:0] vlen, dlen;
    r = $urandom_range(99);
    kind = ($urandom_range(19) == 0) ? $urandom_range(7, 5) : $urandom_range(4);
    vlen = $urandom_range(16);
    dlen = $urandom_range(24);
    if (r < 70)
      build_msg(kind, vlen, dlen, 0, 0, ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
    else if (r < 80)
      build_msg(kind, vlen, dlen, 0, $urandom_range(1, 12), 0);
    else if (r < 88)
      build_msg(kind, vlen, dlen, $urandom_range(1, 3), 0, 0);
    else if (r < 94)
      build_msg(KIND_READ, $urandom_range(1) ? $urandom() : vlen, $urandom(), 0, 0, 0);
    else
      build_noise($urandom_range(1, 6));
  endfunction

  task automatic send_word(word_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = it.w;
    in_tlast = it.last;
    in_tuser = it.kind;
    do @(posedge clk); while (!in_tready);
    sb.note_word(it.w, it.last, it.kind);
    @(negedge clk);
  endtask

  task automatic send_all();
    while (word_q.size() > 0) send_word(word_q.pop_front());
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.results_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int stage, phase_words;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    in_tuser = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_idle_pct = 19;
    recv_idle_pct = 66;
    build_msg(KIND_SINGLE, 0, 0, 0, 0, 0);
    build_msg(KIND_CREATE, 3, 0, 0, 0, 0);
    build_msg(KIND_WRITE, 4, 0, 0, 0, 0);
    // partial last data word, data word carries last
    build_msg(KIND_READ, 0, 5, 0, 0, 0);
    // empty opaque data with trailing words
    build_msg(KIND_READ, 0, 0, 0, 0, 2);
    build_msg(KIND_READSTB, 0, 0, 0, 0, 0);
    build_msg(7, 0, 0, 0, 0, 0);
    build_msg(KIND_WRITE, 0, 0, 1, 0, 0);
    build_msg(KIND_WRITE, 0, 0, 2, 0, 0);
    build_msg(KIND_WRITE, 0, 0, 3, 0, 0);
    // truncated inside opaque data
    build_msg(KIND_READ, 0, 12, 0, 10, 0);
    // longest verifier skip, cut short
    build_msg(KIND_CREATE, 32'hffff_ffff, 0, 0, 0, 0);
    build_noise(1);
    send_all();
    drain();

    for (stage = 0; stage < 3; stage++) begin
      send_idle_pct = (stage == 0) ? 19 : (stage == 1) ? 66 : 0;
      recv_idle_pct = (stage == 0) ? 66 : (stage == 1) ? 19 : 0;
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        random_msg();
        phase_words += word_q.size();
        send_all();
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/rpc_rwp_pkg.sv
rtl/rpc_rwp_parser.sv
rtl/rpc_rwp_out_fifo.sv
rtl/rpc_reply_word_parser_top.sv
tb/tb.sv
